>>> design/fdf4_pkg.sv
// ----------------------------------------------------------------------------
// fdf4_pkg: shared constants and types for the decimate-by-four FIR core
// Default sizes, window geometry, weight format and queue depth.
// ----------------------------------------------------------------------------
package fdf4_pkg;

	localparam int NUM_TAPS_DEF    = 8;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int NUM_WEIGHTS  = 8;
	localparam int WEIGHT_BITS  = 16;
	localparam int CFG_IDX_BITS = 3;
	localparam int WIN_DEPTH    = 8;
	localparam int SEEN_BITS    = 4;
	localparam int PHASE_BITS   = 2;
	localparam int QUEUE_DEPTH  = 2;

	typedef logic signed [WEIGHT_BITS-1:0] weight_t;

	localparam weight_t WEIGHT_RESET = 16'sd4096;

	localparam logic [PHASE_BITS-1:0] PHASE_LAST = 2'd3;
	localparam logic [PHASE_BITS-1:0] EMIT_PHASE = 2'd2;

	localparam logic [1:0] OWED_MAX = 2'd3;
	localparam logic [SEEN_BITS-1:0] SEEN_MAX = 4'd15;

endpackage

>>> design/fdf4_queue.sv
// ----------------------------------------------------------------------------
// fdf4_queue: short FIFO between the front and the back
// Holds filter jobs so that sample intake and arithmetic stall independently.
// ----------------------------------------------------------------------------
module fdf4_queue import fdf4_pkg::*; #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/fdf4_front.sv
// ----------------------------------------------------------------------------
// fdf4_front: sample intake, block tracking and tap selection
// Keeps the sample window and block counters, decides when an output is due
// and hands the selected tap samples with their use mask to the queue.
// ----------------------------------------------------------------------------
module fdf4_front import fdf4_pkg::*; #(
	parameter int NUM_TAPS    = NUM_TAPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int JOB_W       = 1 + NUM_TAPS + NUM_TAPS * SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic                          block_end,
	output logic                          job_valid,
	input  logic                          job_ready,
	output logic [JOB_W-1:0]              job_data
);

	localparam int RUN_BASE = 4 + NUM_TAPS / 2;
	localparam int END_BASE = 1 + NUM_TAPS / 2;

	logic signed [SAMPLE_BITS-1:0] win_q [WIN_DEPTH];
	logic [SEEN_BITS-1:0]          seen_q;
	logic [PHASE_BITS-1:0]         phase_q;
	logic [1:0]                    owed_q;

	logic                          accept, produce;
	logic [1:0]                    owed_inc;
	logic [PHASE_BITS-1:0]         rem;
	logic [5:0]                    age;
	logic [2:0]                    win_idx;
	logic [NUM_TAPS-1:0]           use_vec;
	logic [NUM_TAPS*SAMPLE_BITS-1:0] samp_vec;

	assign in_ready  = job_ready;
	assign accept    = in_valid && in_ready;
	assign job_valid = accept && produce;
	assign job_data  = {block_end, use_vec, samp_vec};

	always_comb begin
		owed_inc = (phase_q == PHASE_LAST && owed_q != OWED_MAX) ? owed_q + 2'd1 : owed_q;
		produce  = block_end ? (owed_inc != 2'd0)
		                     : (phase_q == EMIT_PHASE && owed_inc != 2'd0);
		rem      = phase_q + 1'b1;
		use_vec  = '0;
		samp_vec = '0;
		age      = '0;
		win_idx  = '0;
		for (int c = 0; c < NUM_TAPS; c++) begin
			age = block_end ? (6'(END_BASE) + {4'b0, rem} - 6'(c)) : (6'(RUN_BASE) - 6'(c));
			win_idx = 3'(age - 6'd1);
			use_vec[c] = !age[5] && (age <= 6'(WIN_DEPTH)) && (age <= {2'b00, seen_q});
			samp_vec[c*SAMPLE_BITS +: SAMPLE_BITS] = (age == 6'd0) ? in_sample : win_q[win_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !block_end) begin
			win_q[0] <= in_sample;
			for (int a = 1; a < WIN_DEPTH; a++) begin
				win_q[a] <= win_q[a-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			phase_q <= '0;
			owed_q  <= '0;
		end else if (accept) begin
			if (block_end) begin
				seen_q  <= '0;
				phase_q <= '0;
				owed_q  <= '0;
			end else begin
				owed_q  <= (phase_q == EMIT_PHASE && owed_inc != 2'd0) ? owed_inc - 2'd1 : owed_inc;
				seen_q  <= (seen_q == SEEN_MAX) ? seen_q : seen_q + 1'b1;
				phase_q <= phase_q + 1'b1;
			end
		end
	end

endmodule

>>> design/fdf4_back.sv
// ----------------------------------------------------------------------------
// fdf4_back: shared multiply-accumulate, divider and output register
// One tap per cycle through a registered multiplier, then a restoring
// divide of |sum| by |weight sum|, sign fix, saturation and output beat.
// ----------------------------------------------------------------------------
module fdf4_back import fdf4_pkg::*; #(
	parameter int NUM_TAPS    = NUM_TAPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int JOB_W       = 1 + NUM_TAPS + NUM_TAPS * SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  weight_t                       weights [NUM_WEIGHTS],
	input  logic                          job_valid,
	output logic                          job_ready,
	input  logic [JOB_W-1:0]              job_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	output logic                          out_last
);

	localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS;
	localparam int ACC_W  = SAMPLE_BITS + WEIGHT_BITS + 3;
	localparam int WSUM_W = WEIGHT_BITS + 4;
	localparam int TAP_W  = $clog2(NUM_TAPS + 1);
	localparam int IDX_W  = $clog2(NUM_TAPS);
	localparam int CNT_W  = $clog2(ACC_W);
	localparam int SV_W   = NUM_TAPS * SAMPLE_BITS;

	localparam logic signed [ACC_W:0] SAT_HI = {{(ACC_W-SAMPLE_BITS+2){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [ACC_W:0] SAT_LO = {{(ACC_W-SAMPLE_BITS+2){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAC  = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]               state_q;
	logic [SV_W-1:0]          samp_q;
	logic [NUM_TAPS-1:0]      use_q;
	logic                     last_q;
	logic [TAP_W-1:0]         tap_q;
	logic                     pend_q;
	logic signed [PROD_W-1:0] prod_s1;
	weight_t                  wt_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [WSUM_W-1:0] wsum_q;
	logic [ACC_W-1:0]         dvd_q;
	logic [WSUM_W-1:0]        dvs_q;
	logic [WSUM_W-1:0]        rem_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     neg_q, zero_q;
	logic                     out_valid_q, out_last_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;

	logic [IDX_W-1:0]              tap_idx;
	logic signed [SAMPLE_BITS-1:0] samp_sel;
	weight_t                       wt_sel;
	logic signed [PROD_W-1:0]      mul;
	logic [WSUM_W:0]               rem_sh;
	logic                          qbit;
	logic signed [ACC_W:0]         quot;
	logic signed [SAMPLE_BITS-1:0] sat;
	logic                          out_free;

	assign job_ready  = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_last   = out_last_q;
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		tap_idx  = tap_q[IDX_W-1:0];
		samp_sel = samp_q[tap_idx*SAMPLE_BITS +: SAMPLE_BITS];
		wt_sel   = weights[tap_idx];
		mul      = PROD_W'(samp_sel) * PROD_W'(wt_sel);
		rem_sh   = {rem_q, dvd_q[ACC_W-1]};
		qbit     = (rem_sh >= {1'b0, dvs_q});
		quot     = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
		if (zero_q) begin
			sat = '0;
		end else if (quot > SAT_HI) begin
			sat = SAT_HI[SAMPLE_BITS-1:0];
		end else if (quot < SAT_LO) begin
			sat = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			sat = quot[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				samp_q <= job_data[SV_W-1:0];
				use_q  <= job_data[SV_W +: NUM_TAPS];
				last_q <= job_data[JOB_W-1];
				acc_q  <= '0;
				wsum_q <= '0;
			end
			ST_MAC: begin
				if (pend_q) begin
					acc_q  <= acc_q + ACC_W'(prod_s1);
					wsum_q <= wsum_q + WSUM_W'(wt_s1);
				end
				if (tap_q != TAP_W'(NUM_TAPS)) begin
					prod_s1 <= use_q[tap_idx] ? mul : '0;
					wt_s1   <= use_q[tap_idx] ? wt_sel : '0;
				end
			end
			ST_PREP: begin
				dvd_q  <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
				dvs_q  <= wsum_q[WSUM_W-1] ? WSUM_W'(-wsum_q) : WSUM_W'(wsum_q);
				rem_q  <= '0;
				neg_q  <= acc_q[ACC_W-1] ^ wsum_q[WSUM_W-1];
				zero_q <= (wsum_q == '0);
			end
			ST_DIV: begin
				rem_q <= qbit ? WSUM_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[WSUM_W-1:0];
				dvd_q <= {dvd_q[ACC_W-2:0], qbit};
			end
			default: begin
			end
		endcase
		if (state_q == ST_FIN && out_free) begin
			out_sample_q <= sat;
			out_last_q   <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_q       <= '0;
			pend_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					tap_q  <= '0;
					pend_q <= 1'b0;
					if (job_valid) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (tap_q != TAP_W'(NUM_TAPS)) begin
						tap_q  <= tap_q + 1'b1;
						pend_q <= 1'b1;
					end else begin
						pend_q  <= 1'b0;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(ACC_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/fir_decimate_by_four_core.sv
// ----------------------------------------------------------------------------
// fir_decimate_by_four_core: blocked eight-tap FIR, decimation by four
// Intake takes one sample beat per cycle while the two-entry job queue has room.
// Each output runs through the back end: one tap per cycle on the shared
// multiplier, then one quotient bit per cycle in the divider (ACC_W =
// SAMPLE_BITS + 19 quotient bits); the back takes a new job only when idle.
// Reset clears counters, queue and output valid; tap weights return to 4096.
// ----------------------------------------------------------------------------
module fir_decimate_by_four_core import fdf4_pkg::*; #(
	parameter int NUM_TAPS    = NUM_TAPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [WEIGHT_BITS-1:0]        cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic                          block_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	output logic                          out_last
);

	localparam int JOB_W = 1 + NUM_TAPS + NUM_TAPS * SAMPLE_BITS;

	weight_t          weights_q [NUM_WEIGHTS];
	logic             push_valid, push_ready, pop_valid, pop_ready;
	logic [JOB_W-1:0] push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WEIGHTS; i++) begin
				weights_q[i] <= WEIGHT_RESET;
			end
		end else if (cfg_we) begin
			weights_q[cfg_index] <= cfg_data;
		end
	end

	fdf4_front #(
		.NUM_TAPS    (NUM_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.JOB_W       (JOB_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_sample (in_sample),
		.block_end (block_end),
		.job_valid (push_valid),
		.job_ready (push_ready),
		.job_data  (push_data)
	);

	fdf4_queue #(
		.DATA_W (JOB_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	fdf4_back #(
		.NUM_TAPS    (NUM_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.JOB_W       (JOB_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.weights    (weights_q),
		.job_valid  (pop_valid),
		.job_ready  (pop_ready),
		.job_data   (pop_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_sample (out_sample),
		.out_last   (out_last)
	);

endmodule

>>> test/fdf4_checker.sv
// ----------------------------------------------------------------------------
// fdf4_checker: result checker for the decimate-by-four FIR core
// Watches the config port and both sample channels, predicts every output
// beat from its own copy of window, counters and tap weights, and compares
// each accepted output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module fdf4_checker import fdf4_pkg::*; (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [CFG_IDX_BITS-1:0]           cfg_index,
	input  logic [WEIGHT_BITS-1:0]            cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic signed [SAMPLE_BITS_DEF-1:0] in_sample,
	input  logic                              block_end,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [SAMPLE_BITS_DEF-1:0] out_sample,
	input  logic                              out_last,
	output int                                fails,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DECIM        = 4;
	localparam int EMIT_AGE     = 6;
	localparam int END_AGE_BIAS = 3;
	localparam int TAP_OFFSET   = 2 - NUM_TAPS_DEF / 2;
	localparam longint SAMPLE_HI = (longint'(1) << (SAMPLE_BITS_DEF - 1)) - 1;
	localparam longint SAMPLE_LO = -(longint'(1) << (SAMPLE_BITS_DEF - 1));

	typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

	typedef struct packed {
		sample_t value;
		logic    last;
	} decimated_t;

	decimated_t             due_results[$];
	decimated_t             want;
	sample_t                hist [WIN_DEPTH];
	logic [SEEN_BITS-1:0]   seen;
	logic [PHASE_BITS-1:0]  phase;
	logic [1:0]             owed;
	weight_t                taps [NUM_WEIGHTS];

	function automatic sample_t weighted_mean(sample_t cur, bit at_end, int rem);
		longint acc;
		longint wsum;
		longint q;
		int     age;
		acc  = 0;
		wsum = 0;
		for (int c = 0; c < NUM_TAPS_DEF; c++) begin
			age = at_end ? rem + END_AGE_BIAS - TAP_OFFSET - c : EMIT_AGE - TAP_OFFSET - c;
			if (age >= 0 && age <= WIN_DEPTH && age <= int'(seen)) begin
				acc  += longint'(age == 0 ? cur : hist[age-1]) * longint'(taps[c]);
				wsum += longint'(taps[c]);
			end
		end
		q = (wsum == 0) ? 0 : acc / wsum;
		if (q > SAMPLE_HI) q = SAMPLE_HI;
		if (q < SAMPLE_LO) q = SAMPLE_LO;
		return sample_t'(q);
	endfunction

	task automatic clear_block();
		for (int a = 0; a < WIN_DEPTH; a++) hist[a] = '0;
		seen  = '0;
		phase = '0;
		owed  = '0;
	endtask

	task automatic take_beat(sample_t cur, logic fin);
		decimated_t r;
		bit         made;
		made   = 1'b0;
		r.last = fin;
		r.value = '0;
		if (phase == PHASE_LAST && owed < OWED_MAX) owed = owed + 1'b1;
		if (fin) begin
			if (owed != 0) begin
				r.value = weighted_mean(cur, 1'b1, (int'(phase) + 1) % DECIM);
				made = 1'b1;
			end
		end else if (phase == EMIT_PHASE && owed != 0) begin
			r.value = weighted_mean(cur, 1'b0, 0);
			owed = owed - 1'b1;
			made = 1'b1;
		end
		if (made) due_results.push_back(r);
		if (fin) begin
			clear_block();
		end else begin
			for (int a = WIN_DEPTH - 1; a > 0; a--) hist[a] = hist[a-1];
			hist[0] = cur;
			if (seen < SEEN_MAX) seen = seen + 1'b1;
			phase = phase + 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_block();
			for (int i = 0; i < NUM_WEIGHTS; i++) taps[i] = WEIGHT_RESET;
			due_results.delete();
			fails   = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("out beat with nothing due: out_sample %0d out_last %0b",
						out_sample, out_last);
					fails++;
				end else begin
					want = due_results.pop_front();
					if (out_sample !== want.value) begin
						$error("out_sample: expected %0d, got %0d",
							$signed(want.value), out_sample);
						fails++;
					end
					if (out_last !== want.last) begin
						$error("out_last: expected %0b, got %0b", want.last, out_last);
						fails++;
					end
				end
			end
			if (cfg_we && int'(cfg_index) < NUM_WEIGHTS) taps[cfg_index] = weight_t'(cfg_data);
			if (in_valid && in_ready) take_beat(in_sample, block_end);
			pending = due_results.size();
		end
	end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the decimate-by-four FIR core
// Drives directed and random sample blocks under several tap weight sets,
// with random gaps on the input and output channels, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fdf4_pkg::*;

	localparam int DRAIN_CYCLES = 60;

	typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

	typedef enum int {
		TAPS_MAX, TAPS_MIN, TAPS_RANDOM, TAPS_ZERO_SUM,
		TAPS_SATURATE, TAPS_ZERO, TAPS_SPARSE, TAPS_DEFAULT
	} tap_set_e;

	localparam sample_t S_MAX = 16'sh7FFF;
	localparam sample_t S_MIN = 16'sh8000;
	localparam weight_t W_MAX = 16'sh7FFF;
	localparam weight_t W_MIN = 16'sh8000;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [WEIGHT_BITS-1:0]  cfg_data  = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	sample_t                 in_sample = '0;
	logic                    block_end = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	sample_t                 out_sample;
	logic                    out_last;
	int                      fails;
	int                      pending;

	bit      tx_calm = 1'b0;
	bit      rx_calm = 1'b0;
	int      rx_hold = 0;
	sample_t block_q[$];
	weight_t next_taps [NUM_WEIGHTS];

	fir_decimate_by_four_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_sample  (in_sample),
		.block_end  (block_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_sample (out_sample),
		.out_last   (out_last)
	);

	fdf4_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_sample  (in_sample),
		.block_end  (block_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_sample (out_sample),
		.out_last   (out_last),
		.fails      (fails),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic sample_t pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return sample_t'($urandom);
		if (r < 62) return S_MAX;
		if (r < 74) return S_MIN;
		if (r < 88) return sample_t'(int'($urandom_range(0, 600)) - 300);
		if (r < 94) return S_MAX - sample_t'($urandom_range(0, 15));
		return S_MIN + sample_t'($urandom_range(0, 15));
	endfunction

	// output side back-pressure
	always @(negedge clk) begin
		if (rx_hold != 0) begin
			rx_hold   <= rx_hold - 1;
			out_ready <= 1'b0;
		end else begin
			automatic int g = pick_gap(rx_calm);
			if (g == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				rx_hold   <= g - 1;
			end
		end
	end

	task automatic send_beat(sample_t s, logic fin);
		in_valid  <= 1'b1;
		in_sample <= s;
		block_end <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// sends block_q with block_end on its last beat
	task automatic send_block();
		int gap;
		for (int k = 0; k < block_q.size(); k++) begin
			send_beat(block_q[k], k == block_q.size() - 1);
			gap = pick_gap(tx_calm);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic run_blocks(int n);
		int sent;
		int len;
		int r;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 75) len = $urandom_range(4, 20);
			else if (r < 88) len = $urandom_range(1, 3);
			else len = $urandom_range(21, 45);
			block_q.delete();
			repeat (len) block_q.push_back(pick_sample());
			send_block();
			sent += len;
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic load_taps();
		for (int i = 0; i < NUM_WEIGHTS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_BITS'(i);
			cfg_data  <= next_taps[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic pick_taps(tap_set_e set);
		weight_t w;
		for (int i = 0; i < NUM_WEIGHTS; i++) begin
			case (set)
				TAPS_MAX:      next_taps[i] = W_MAX;
				TAPS_MIN:      next_taps[i] = W_MIN;
				TAPS_RANDOM:   next_taps[i] = weight_t'($urandom);
				TAPS_ZERO_SUM: begin
					if (i % 2 == 0) begin
						w = weight_t'(int'($urandom_range(0, 65534)) - 32767);
						next_taps[i] = w;
					end else begin
						next_taps[i] = -next_taps[i-1];
					end
				end
				TAPS_SATURATE: next_taps[i] = (i == 0) ? W_MIN : (i == 1) ? W_MAX : '0;
				TAPS_ZERO:     next_taps[i] = '0;
				TAPS_SPARSE:   next_taps[i] = $urandom_range(0, 1) ? weight_t'($urandom) : '0;
				default:       next_taps[i] = WEIGHT_RESET;
			endcase
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// short block, minimal block, mixed extremes under reset weights
		block_q = '{S_MIN, S_MAX};
		send_block();
		block_q = '{S_MAX, S_MAX, S_MAX, S_MAX};
		send_block();
		block_q = '{S_MIN, S_MAX, -1, 1, S_MAX, S_MIN, 0, S_MAX};
		send_block();
		run_blocks(50);

		for (int k = 0; k <= TAPS_DEFAULT; k++) begin
			settle();
			pick_taps(tap_set_e'(k));
			load_taps();
			tx_calm <= ($urandom_range(0, 3) == 0);
			rx_calm <= ($urandom_range(0, 3) == 0);
			case (tap_set_e'(k))
				TAPS_SATURATE: begin
					// first output has zero weight sum, then clamp high and low
					block_q = '{0, 0, S_MAX, S_MIN, 0, 0, S_MIN, S_MAX, 0, 0, 0, 0};
					send_block();
					run_blocks(50);
				end
				TAPS_RANDOM: begin
					run_blocks(25);
					settle();
					run_blocks(25);
				end
				default: run_blocks(50);
			endcase
		end

		settle();
		if (fails == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
